// ----- rtl/sbs_pkg.sv -----
// Shared types, codes and helper functions for the self-avoiding walk step block.
`default_nettype none
package sbs_pkg;

	typedef logic [1:0] dir_t;

	localparam dir_t DIR_PX = 2'd0;
	localparam dir_t DIR_NX = 2'd1;
	localparam dir_t DIR_PY = 2'd2;
	localparam dir_t DIR_NY = 2'd3;

	typedef enum logic [2:0] {
		OUT_EXTENDED  = 3'd0,
		OUT_RETRACTED = 3'd1,
		OUT_NEUTRAL   = 3'd2,
		OUT_REJECTED  = 3'd3,
		OUT_BLOCKED   = 3'd4,
		OUT_RETRY     = 3'd5,
		OUT_FINISHED  = 3'd6
	} outcome_t;

	typedef enum logic [1:0] {
		REG_UP     = 2'd0,
		REG_DOWN   = 2'd1,
		REG_TARGET = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_ORIGIN,
		MODE_EXTEND,
		MODE_NEUTRAL,
		MODE_RETRACT
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ORG_WR,
		ST_FETCH0,
		ST_FETCH1,
		ST_FETCH2,
		ST_PICK,
		ST_SCAN,
		ST_COMMIT,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic done;
		logic hit;
	} scan_status_t;

	localparam logic [6:0]  PCT_FULL     = 7'd100;
	localparam logic [6:0]  UP_RESET     = 7'd100;
	localparam logic [6:0]  DOWN_RESET   = 7'd85;
	localparam logic [10:0] TARGET_RESET = 11'd1000;

	function automatic logic passes(input logic [6:0] thr, input logic [6:0] draw);
		return (thr >= PCT_FULL) || (draw <= thr);
	endfunction

	// remainder by three of a 4-bit draw
	function automatic logic [1:0] mod3(input logic [3:0] v);
		logic [1:0] r;
		unique case (v)
			4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
			4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
			default:                              r = 2'd2;
		endcase
		return r;
	endfunction

	// pick among the codes not excluded, counted in ascending order
	function automatic dir_t pick_dir(input logic [3:0] excl, input logic [3:0] draw);
		logic [2:0] cnt;
		logic [1:0] k;
		dir_t       res;
		logic       found;
		cnt = 3'd0;
		for (int c = 0; c < 4; c++) begin
			if (!excl[c]) cnt = cnt + 3'd1;
		end
		unique case (cnt)
			3'd4:    k = draw[1:0];
			3'd3:    k = mod3(draw);
			3'd2:    k = {1'b0, draw[0]};
			default: k = 2'd0;
		endcase
		res = DIR_PX;
		found = 1'b0;
		for (int c = 0; c < 4; c++) begin
			if (!excl[c] && !found) begin
				if (k == 2'd0) begin
					res = dir_t'(c);
					found = 1'b1;
				end else begin
					k = k - 2'd1;
				end
			end
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/sbs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/sbs_scan.sv -----
// Occupancy scan: walks the site stack one entry a cycle against a candidate site.
`default_nettype none
module sbs_scan #(
	parameter int MAX_LEN = 1024,
	parameter int SITE_W  = 22
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [$clog2(MAX_LEN+1)-1:0] count,
	input  wire logic [SITE_W-1:0]            target,
	input  wire logic [SITE_W-1:0]            rdata,
	output logic      [$clog2(MAX_LEN)-1:0]   addr,
	output sbs_pkg::scan_status_t             status
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int LW = $clog2(MAX_LEN + 1);

	logic [LW-1:0] idx_q;
	logic          running_q;
	logic          cmp_q;
	logic          last_q;
	logic          done_q;
	logic          hit_q;
	logic          is_last;

	assign is_last = (idx_q + LW'(1)) == count;
	assign addr    = idx_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			running_q <= 1'b0;
			cmp_q     <= 1'b0;
			last_q    <= 1'b0;
			done_q    <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			cmp_q  <= running_q && !start;
			last_q <= running_q && is_last && !start;
			done_q <= last_q && !start;
			if (start) begin
				idx_q     <= '0;
				running_q <= 1'b1;
				hit_q     <= 1'b0;
			end else begin
				if (running_q) begin
					idx_q <= idx_q + LW'(1);
					if (is_last) running_q <= 1'b0;
				end
				// the RAM registers its read data, so it belongs to the address given before
				if (cmp_q && (rdata == target)) hit_q <= 1'b1;
			end
		end
	end

	assign status.done = done_q;
	assign status.hit  = hit_q;

endmodule
`default_nettype wire

// ----- rtl/saw_berretti_sokal_step.sv -----
// Top level of the self-avoiding walk Monte Carlo step block.
//
// Usage: drive one attempt's draws and pulse start while busy is low; the
// attempt is taken at that clock edge and busy stays high until its result
// has been shown. Exactly one result follows each attempt: result_valid is
// high for one cycle with walk_length, end_x, end_y, outcome, retry_pending
// and done_res. The receiver cannot stall; the result must be taken then.
// Sequence: finished walks, attempts rejected by the percent test and
// extensions of a full walk go straight to the result. An origin extension
// writes the origin site, then commits. Retractions fetch, pick and commit.
// Extensions and neutral moves add the occupancy scan over the walk's sites,
// which reads one site per cycle from the site stack's single read port.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while busy is low.
// Reset: the walk returns to the origin (one site), retry is cleared and the
// registers take 100, 85 and 1000. The stacks are not cleared; every entry
// whose value is used has been written since the walk last left the origin.
`default_nettype none
module saw_berretti_sokal_step #(
	parameter int MAX_LEN = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        atmosphere_draw,
	input  wire logic        kind_draw,
	input  wire logic [6:0]  accept_draw,
	input  wire logic [3:0]  direction_draw,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [10:0] cfg_data,
	output logic             result_valid,
	output logic [10:0]      walk_length,
	output logic signed [10:0] end_x,
	output logic signed [10:0] end_y,
	output logic [2:0]       outcome,
	output logic             retry_pending,
	output logic             done_res
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int CW = AW + 1;
	localparam int SW = 2 * CW;
	localparam int XW = (CW > 11) ? CW : 11;
	localparam int TW = (LW > 11) ? LW : 11;

	sbs_pkg::state_t   state_q, state_d;
	sbs_pkg::mode_t    mode_q, mode_d;
	sbs_pkg::outcome_t outcome_q, early_outcome;
	logic              early;

	logic [6:0]  up_q;
	logic [6:0]  down_q;
	logic [10:0] target_q;

	logic [LW-1:0]        n_q;
	logic signed [CW-1:0] end_x_q, end_y_q;
	logic                 retry_q;
	logic                 retry_atm_q;

	logic                 atm_q;
	logic [3:0]           ddraw_q;
	sbs_pkg::dir_t        d_q, last_dir_q, prev_dir_q;
	logic signed [CW-1:0] base_x_q, base_y_q;
	logic signed [CW-1:0] new_x_q, new_y_q;

	logic          accept;
	logic          finished;
	logic          at_origin;
	logic          full;
	logic          atm_eff;
	sbs_pkg::dir_t origin_dir;
	sbs_pkg::dir_t walk_dir;
	logic [3:0]    excl;

	logic [LW-1:0] n_m1, n_m2, n_m3;

	// shared step adder
	logic signed [CW-1:0] src_x, src_y, step_x, step_y;
	sbs_pkg::dir_t        step_dir;

	// memory ports
	logic          dir_we, site_we;
	logic [AW-1:0] dir_waddr, site_waddr, dir_raddr, site_raddr;
	sbs_pkg::dir_t dir_wdata, dir_rdata;
	logic [SW-1:0] site_wdata, site_rdata;

	logic                  scan_start;
	logic [LW-1:0]         scan_count;
	logic [AW-1:0]         scan_addr;
	sbs_pkg::scan_status_t scan_status;

	logic signed [XW-1:0] end_x_ext, end_y_ext;
	logic [TW-1:0]        n_ext;

	assign n_m1      = n_q - LW'(1);
	assign n_m2      = n_q - LW'(2);
	assign n_m3      = n_q - LW'(3);
	assign n_ext     = TW'(n_q);
	assign finished  = n_ext >= TW'(target_q);
	assign at_origin = n_q <= LW'(1);
	assign full      = n_q >= LW'(MAX_LEN);
	assign accept    = start && (state_q == sbs_pkg::ST_IDLE);
	assign atm_eff   = retry_q ? retry_atm_q : atmosphere_draw;
	assign origin_dir = sbs_pkg::pick_dir(4'b0000, direction_draw);

	// classify the attempt at acceptance
	always_comb begin
		mode_d        = sbs_pkg::MODE_ORIGIN;
		early         = 1'b0;
		early_outcome = sbs_pkg::OUT_EXTENDED;
		priority if (finished) begin
			early         = 1'b1;
			early_outcome = sbs_pkg::OUT_FINISHED;
		end else if (at_origin) begin
			mode_d = sbs_pkg::MODE_ORIGIN;
			if (!sbs_pkg::passes(up_q, accept_draw)) begin
				early         = 1'b1;
				early_outcome = sbs_pkg::OUT_REJECTED;
			end
		end else if (!kind_draw) begin
			mode_d = sbs_pkg::MODE_NEUTRAL;
		end else if (!atm_eff) begin
			mode_d = sbs_pkg::MODE_EXTEND;
			if (!sbs_pkg::passes(up_q, accept_draw)) begin
				early         = 1'b1;
				early_outcome = sbs_pkg::OUT_REJECTED;
			end else if (full) begin
				early         = 1'b1;
				early_outcome = sbs_pkg::OUT_BLOCKED;
			end
		end else begin
			mode_d = sbs_pkg::MODE_RETRACT;
			if (!sbs_pkg::passes(down_q, accept_draw)) begin
				early         = 1'b1;
				early_outcome = sbs_pkg::OUT_REJECTED;
			end
		end
	end

	// direction choice for extension and neutral moves
	always_comb begin
		if (mode_q == sbs_pkg::MODE_NEUTRAL) begin
			excl = 4'b0001 << last_dir_q;
			if (n_q >= LW'(3)) excl = excl | (4'b0001 << (prev_dir_q ^ 2'b01));
		end else begin
			excl = 4'b0001 << (last_dir_q ^ 2'b01);
		end
		walk_dir = sbs_pkg::pick_dir(excl, ddraw_q);
	end

	always_comb begin
		if (state_q == sbs_pkg::ST_IDLE) begin
			src_x    = '0;
			src_y    = '0;
			step_dir = origin_dir;
		end else if (mode_q == sbs_pkg::MODE_NEUTRAL) begin
			src_x    = base_x_q;
			src_y    = base_y_q;
			step_dir = walk_dir;
		end else begin
			src_x    = end_x_q;
			src_y    = end_y_q;
			step_dir = walk_dir;
		end
		step_x = src_x;
		step_y = src_y;
		unique case (step_dir)
			sbs_pkg::DIR_PX: step_x = src_x + CW'(1);
			sbs_pkg::DIR_NX: step_x = src_x - CW'(1);
			sbs_pkg::DIR_PY: step_y = src_y + CW'(1);
			sbs_pkg::DIR_NY: step_y = src_y - CW'(1);
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sbs_pkg::ST_IDLE: begin
				if (accept) begin
					priority if (early) state_d = sbs_pkg::ST_RESP;
					else if (mode_d == sbs_pkg::MODE_ORIGIN) state_d = sbs_pkg::ST_ORG_WR;
					else state_d = sbs_pkg::ST_FETCH0;
				end
			end
			sbs_pkg::ST_ORG_WR: state_d = sbs_pkg::ST_COMMIT;
			sbs_pkg::ST_FETCH0: state_d = sbs_pkg::ST_FETCH1;
			sbs_pkg::ST_FETCH1: state_d = sbs_pkg::ST_FETCH2;
			sbs_pkg::ST_FETCH2: state_d = sbs_pkg::ST_PICK;
			sbs_pkg::ST_PICK: begin
				if (mode_q == sbs_pkg::MODE_RETRACT) state_d = sbs_pkg::ST_COMMIT;
				else state_d = sbs_pkg::ST_SCAN;
			end
			sbs_pkg::ST_SCAN: begin
				if (scan_status.done) state_d = sbs_pkg::ST_COMMIT;
			end
			sbs_pkg::ST_COMMIT: state_d = sbs_pkg::ST_RESP;
			sbs_pkg::ST_RESP:   state_d = sbs_pkg::ST_IDLE;
			default:            state_d = sbs_pkg::ST_IDLE;
		endcase
	end

	// state outputs: memory ports, scan launch, handshake
	always_comb begin
		busy         = state_q != sbs_pkg::ST_IDLE;
		result_valid = state_q == sbs_pkg::ST_RESP;
		scan_start   = (state_q == sbs_pkg::ST_PICK) && (mode_q != sbs_pkg::MODE_RETRACT);
		dir_raddr    = (state_q == sbs_pkg::ST_FETCH1) ? n_m3[AW-1:0] : n_m2[AW-1:0];
		site_raddr   = (state_q == sbs_pkg::ST_SCAN) ? scan_addr : n_m2[AW-1:0];
		dir_we       = 1'b0;
		dir_waddr    = n_m2[AW-1:0];
		dir_wdata    = d_q;
		site_we      = 1'b0;
		site_waddr   = n_m1[AW-1:0];
		site_wdata   = {new_y_q, new_x_q};
		if (state_q == sbs_pkg::ST_ORG_WR) begin
			// origin site goes back in as site zero
			site_we    = 1'b1;
			site_waddr = '0;
			site_wdata = '0;
		end else if (state_q == sbs_pkg::ST_COMMIT) begin
			unique case (mode_q)
				sbs_pkg::MODE_ORIGIN: begin
					dir_we     = 1'b1;
					dir_waddr  = '0;
					site_we    = 1'b1;
					site_waddr = AW'(1);
				end
				sbs_pkg::MODE_EXTEND: begin
					dir_we     = !scan_status.hit;
					dir_waddr  = n_m1[AW-1:0];
					site_we    = !scan_status.hit;
					site_waddr = n_q[AW-1:0];
				end
				sbs_pkg::MODE_NEUTRAL: begin
					dir_we  = !scan_status.hit;
					site_we = !scan_status.hit;
				end
				sbs_pkg::MODE_RETRACT: ;
				default: ;
			endcase
		end
	end

	assign scan_count = (mode_q == sbs_pkg::MODE_NEUTRAL) ? n_m1 : n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q     <= sbs_pkg::UP_RESET;
			down_q   <= sbs_pkg::DOWN_RESET;
			target_q <= sbs_pkg::TARGET_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sbs_pkg::REG_UP:     up_q     <= cfg_data[6:0];
				sbs_pkg::REG_DOWN:   down_q   <= cfg_data[6:0];
				sbs_pkg::REG_TARGET: target_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= LW'(1);
			end_x_q     <= '0;
			end_y_q     <= '0;
			retry_q     <= 1'b0;
			retry_atm_q <= 1'b0;
		end else begin
			if (accept && !finished) retry_q <= 1'b0;
			if (state_q == sbs_pkg::ST_COMMIT) begin
				unique case (mode_q)
					sbs_pkg::MODE_ORIGIN: begin
						n_q     <= LW'(2);
						end_x_q <= new_x_q;
						end_y_q <= new_y_q;
					end
					sbs_pkg::MODE_EXTEND: begin
						if (!scan_status.hit) begin
							n_q     <= n_q + LW'(1);
							end_x_q <= new_x_q;
							end_y_q <= new_y_q;
						end
					end
					sbs_pkg::MODE_NEUTRAL: begin
						if (scan_status.hit) begin
							retry_q     <= 1'b1;
							retry_atm_q <= ~atm_q;
						end else begin
							end_x_q <= new_x_q;
							end_y_q <= new_y_q;
						end
					end
					sbs_pkg::MODE_RETRACT: begin
						n_q     <= n_m1;
						end_x_q <= base_x_q;
						end_y_q <= base_y_q;
					end
					default: ;
				endcase
			end
		end
	end

	// attempt payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q    <= mode_d;
			atm_q     <= atm_eff;
			ddraw_q   <= direction_draw;
			outcome_q <= early_outcome;
			d_q       <= origin_dir;
			new_x_q   <= step_x;
			new_y_q   <= step_y;
		end
		if (state_q == sbs_pkg::ST_FETCH1) begin
			last_dir_q <= dir_rdata;
			base_x_q   <= site_rdata[CW-1:0];
			base_y_q   <= site_rdata[SW-1:CW];
		end
		if (state_q == sbs_pkg::ST_FETCH2) prev_dir_q <= dir_rdata;
		if (state_q == sbs_pkg::ST_PICK) begin
			d_q     <= walk_dir;
			new_x_q <= step_x;
			new_y_q <= step_y;
		end
		if (state_q == sbs_pkg::ST_COMMIT) begin
			unique case (mode_q)
				sbs_pkg::MODE_ORIGIN:  outcome_q <= sbs_pkg::OUT_EXTENDED;
				sbs_pkg::MODE_EXTEND:  outcome_q <= scan_status.hit ? sbs_pkg::OUT_BLOCKED
				                                                    : sbs_pkg::OUT_EXTENDED;
				sbs_pkg::MODE_NEUTRAL: outcome_q <= scan_status.hit ? sbs_pkg::OUT_RETRY
				                                                    : sbs_pkg::OUT_NEUTRAL;
				sbs_pkg::MODE_RETRACT: outcome_q <= sbs_pkg::OUT_RETRACTED;
				default: ;
			endcase
		end
	end

	sbs_ram #(
		.WIDTH(2),
		.DEPTH(MAX_LEN)
	) u_dir_ram (
		.clk  (clk),
		.we   (dir_we),
		.waddr(dir_waddr),
		.wdata(dir_wdata),
		.raddr(dir_raddr),
		.rdata(dir_rdata)
	);

	sbs_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_LEN)
	) u_site_ram (
		.clk  (clk),
		.we   (site_we),
		.waddr(site_waddr),
		.wdata(site_wdata),
		.raddr(site_raddr),
		.rdata(site_rdata)
	);

	sbs_scan #(
		.MAX_LEN(MAX_LEN),
		.SITE_W (SW)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.start (scan_start),
		.count (scan_count),
		.target({new_y_q, new_x_q}),
		.rdata (site_rdata),
		.addr  (scan_addr),
		.status(scan_status)
	);

	assign end_x_ext     = XW'(end_x_q);
	assign end_y_ext     = XW'(end_y_q);
	assign walk_length   = n_ext[10:0];
	assign end_x         = end_x_ext[10:0];
	assign end_y         = end_y_ext[10:0];
	assign outcome       = outcome_q;
	assign retry_pending = retry_q;
	assign done_res      = finished;

endmodule
`default_nettype wire

// ----- rtl/sbs_check.sv -----
// Port-level checker for the walk step block, bound to the top level.
`default_nettype none
module sbs_check (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       result_valid,
	input wire logic [2:0] outcome,
	input wire logic       retry_pending,
	input wire logic       done_res
);

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held for more than one cycle");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after a transfer");

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result shown while idle");

	a_finished_done: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (outcome == sbs_pkg::OUT_FINISHED)) |-> done_res)
		else $error("finished outcome without done");

	a_retry_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (outcome != sbs_pkg::OUT_FINISHED))
		|-> (retry_pending == (outcome == sbs_pkg::OUT_RETRY)))
		else $error("retry flag does not match outcome");

endmodule

bind saw_berretti_sokal_step sbs_check u_check (.*);
`default_nettype wire
